// File: hdl/iec958_subframe_builder_defines.svh
// ----------------------------------------------------------------------------
// iec958_subframe_builder_defines
// Assertion macros for the IEC958 subframe builder.
// ----------------------------------------------------------------------------
`ifndef IEC958_SUBFRAME_BUILDER_DEFINES_SVH
`define IEC958_SUBFRAME_BUILDER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ISB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ISB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg
// Constants and subframe packing for the IEC958 subframe builder.
// ----------------------------------------------------------------------------
package isb_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int SUBFRAME_W       = 32;
	localparam int STATUS_W         = 64;
	localparam int CFG_INDEX_W      = 2;
	localparam int CNT_W            = 8;
	localparam int FRAMES_PER_BLOCK = 192;
	localparam int SAMPLE_LSB       = 11;
	localparam int STATUS_BIT       = 29;
	localparam int PARITY_BIT       = 30;
	localparam int BLOCK_BIT        = 31;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_STATUS_LOW  = 2'd0;
	localparam cfg_index_t REG_STATUS_MID  = 2'd1;
	localparam cfg_index_t REG_STATUS_HIGH = 2'd2;

	typedef logic [SUBFRAME_W-1:0] subframe_t;

	// B P C U V | sample | zeros; parity is even over the sample and C
	function automatic subframe_t build_subframe(input logic [SAMPLE_W-1:0] sample,
			input logic status, input logic block_start);
		subframe_t word;
		word = '0;
		word[SAMPLE_LSB +: SAMPLE_W] = sample;
		word[STATUS_BIT]             = status;
		word[PARITY_BIT]             = (^sample) ^ status;
		word[BLOCK_BIT]              = block_start;
		return word;
	endfunction

endpackage

// File: hdl/iec958_subframe_builder.sv
// ----------------------------------------------------------------------------
// iec958_subframe_builder
// Packs one stereo frame into two IEC958 subframes with channel status,
// parity and block start taken from a 192-frame counter.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_stall  | left_sample, right_sample
//  out     | out_valid / out_stall| left_subframe, right_subframe
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One frame per cycle while no stall holds it; a frame is registered in
// the input register and then in the result register before it leaves.
// Input register then result register; subframe logic sits between them.
// A stalled output holds the result register; the input side stalls only
// when the input register is full and cannot move on.
// Reset clears the frame counter, the status words and the valid flags.
module iec958_subframe_builder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [isb_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [isb_pkg::SAMPLE_W-1:0] right_sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [isb_pkg::SUBFRAME_W-1:0]   left_subframe,
	output logic [isb_pkg::SUBFRAME_W-1:0]   right_subframe,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  isb_pkg::cfg_index_t              cfg_index,
	input  logic [isb_pkg::STATUS_W-1:0]     cfg_data
);
	import isb_pkg::*;

	`include "iec958_subframe_builder_defines.svh"

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAMES_PER_BLOCK - 1);

	logic [STATUS_W-1:0] status_low_q, status_mid_q, status_high_q;
	logic [CNT_W-1:0]    frame_cnt_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] left_s1, right_s1;
	logic [CNT_W-1:0]    cnt_s1;

	logic      out_move, s1_move, in_xfer;
	logic [STATUS_W-1:0] status_word;
	logic      status_bit, block_start;

	assign cfg_ready = 1'b1;

	assign out_move = !out_valid || !out_stall;
	assign s1_move  = !valid_s1 || out_move;
	assign in_stall = !s1_move;
	assign in_xfer  = in_valid && s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_low_q  <= '0;
			status_mid_q  <= '0;
			status_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STATUS_LOW:  status_low_q  <= cfg_data;
				REG_STATUS_MID:  status_mid_q  <= cfg_data;
				REG_STATUS_HIGH: status_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
		end else if (in_xfer) begin
			frame_cnt_q <= (frame_cnt_q == CNT_LAST) ? '0 : frame_cnt_q + 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_move) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_s1  <= left_sample;
			right_s1 <= right_sample;
			cnt_s1   <= frame_cnt_q;
		end
	end

	// counter stays below 192, so the top two bits pick the word
	always_comb begin
		unique case (cnt_s1[CNT_W-1 -: 2])
			2'd0:    status_word = status_low_q;
			2'd1:    status_word = status_mid_q;
			default: status_word = status_high_q;
		endcase
	end

	assign status_bit  = status_word[cnt_s1[5:0]];
	assign block_start = (cnt_s1 == '0);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_move) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_move && valid_s1) begin
			left_subframe  <= build_subframe(left_s1, status_bit, block_start);
			right_subframe <= build_subframe(right_s1, status_bit, block_start);
		end
	end

	`ISB_ASSERT_IMP(a_cnt_range, 1'b1, frame_cnt_q <= CNT_LAST, "frame counter out of range")
	`ISB_ASSERT_NXT(a_cnt_step, in_valid && !in_stall,
		frame_cnt_q == (($past(frame_cnt_q) == CNT_LAST) ? '0 : $past(frame_cnt_q) + 1'b1),
		"frame counter did not advance on transfer")
	`ISB_ASSERT_IMP(a_shared_flags, out_valid,
		left_subframe[BLOCK_BIT] == right_subframe[BLOCK_BIT] &&
		left_subframe[STATUS_BIT] == right_subframe[STATUS_BIT],
		"subframes of one frame disagree on status or block start")
	`ISB_ASSERT_NXT(a_s1_held, valid_s1 && !s1_move && !out_move, valid_s1,
		"input register lost a held frame")

endmodule
